// ----- sv/gerd_pkg.sv -----
// Shared constants, types and arithmetic helpers for the elimination block.
package gerd_pkg;

  localparam int MAX_DIM   = 8;
  localparam int FRAC_BITS = 24;

  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int POS_W   = ADDR_W + 1;

  localparam int ELEM_W  = 32;
  localparam int CNT_W   = 4;
  localparam int EPS_W   = 16;
  localparam int RANK_W  = 4;
  localparam int ENT_W   = 48;
  localparam int DET_W   = 64;
  localparam int DIG_W   = 16;
  localparam int DIGITS  = ENT_W / DIG_W;
  localparam int PROD_W  = DET_W + ENT_W;
  localparam int REM_W   = ENT_W + 1;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam int Q_UP = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int Q_DN = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

  localparam logic signed [ENT_W-1:0] ENT_MAX = {1'b0, {(ENT_W-1){1'b1}}};
  localparam logic signed [ENT_W-1:0] ENT_MIN = {1'b1, {(ENT_W-1){1'b0}}};
  localparam logic signed [DET_W-1:0] DET_ONE = DET_W'(64'd1 << 32);

  typedef enum logic [1:0] {
    REG_ROWS = 2'd0,
    REG_COLS = 2'd1,
    REG_EPS  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic                     start;
    logic                     wide;
    logic signed [DET_W-1:0]  x;
    logic signed [ENT_W-1:0]  y;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic                     sat;
    logic signed [DET_W-1:0]  value;
  } mul_rsp_t;

  typedef struct packed {
    logic                     start;
    logic signed [ENT_W-1:0]  num;
    logic signed [ENT_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic                     sat;
    logic signed [ENT_W-1:0]  coef;
  } div_rsp_t;

  // Q16.16 to internal format; rounds toward minus infinity when narrowing
  function automatic logic signed [ENT_W-1:0] q16_to_ent(input logic signed [ELEM_W-1:0] v);
    logic signed [ENT_W-1:0] w;
    w = ENT_W'(v);
    w = w <<< Q_UP;
    return w >>> Q_DN;
  endfunction

  function automatic logic [ENT_W-1:0] mag_ent(input logic signed [ENT_W-1:0] v);
    return v[ENT_W-1] ? ENT_W'(-v) : ENT_W'(v);
  endfunction

endpackage

// ----- sv/gerd_in_if.sv -----
// Element input channel: one matrix element per transfer.
interface gerd_in_if
  import gerd_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] element_value;
  logic                     last_element;

  modport source(output valid, output element_value, output last_element, input ready);
  modport sink(input valid, input element_value, input last_element, output ready);
endinterface

// ----- sv/gerd_out_if.sv -----
// Result channel: rank, determinant and saturation flag per matrix.
interface gerd_out_if
  import gerd_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [RANK_W-1:0]        rank;
  logic signed [DET_W-1:0]  determinant;
  logic                     det_saturated;

  modport source(output valid, output rank, output determinant, output det_saturated,
                 input ready);
  modport sink(input valid, input rank, input determinant, input det_saturated,
               output ready);
endinterface

// ----- sv/gerd_store.sv -----
// Matrix store: one write port, one read port, registered read data.
module gerd_store
  import gerd_pkg::*;
(
  input  logic                     clk,
  input  logic                     we,
  input  logic [ADDR_W-1:0]        waddr,
  input  logic signed [ENT_W-1:0]  wdata,
  input  logic                     re,
  input  logic [ADDR_W-1:0]        raddr,
  output logic signed [ENT_W-1:0]  rdata
);

  logic signed [ENT_W-1:0] mem [DEPTH];
  logic signed [ENT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/gerd_mul.sv -----
// Sequential signed multiplier: (x * y) >> FRAC_BITS, truncated, saturated.
module gerd_mul
  import gerd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam int CW = $clog2(DIGITS);

  logic                    busy_r, fin_r, done_r;
  logic [CW-1:0]           cnt_r;
  logic [DET_W-1:0]        a_r;
  logic [ENT_W-1:0]        b_r;
  logic                    neg_r, wide_r;
  logic [PROD_W-1:0]       acc_r;
  logic                    sat_r;
  logic signed [DET_W-1:0] value_r;

  logic [DET_W+DIG_W-1:0]  pp;
  logic [DET_W-1:0]        mag, pos_lim, neg_lim, mag_cap;
  logic                    ovf;

  assign pp = a_r * b_r[ENT_W-1 -: DIG_W];

  always_comb begin
    pos_lim = wide_r ? {1'b0, {(DET_W-1){1'b1}}} : DET_W'({1'b0, {(ENT_W-1){1'b1}}});
    neg_lim = wide_r ? {1'b1, {(DET_W-1){1'b0}}} : DET_W'({1'b1, {(ENT_W-1){1'b0}}});
    mag = (|acc_r[PROD_W-1:FRAC_BITS+DET_W]) ? {DET_W{1'b1}} : acc_r[FRAC_BITS +: DET_W];
    ovf = neg_r ? (mag > neg_lim) : (mag > pos_lim);
    mag_cap = ovf ? (neg_r ? neg_lim : pos_lim) : mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        a_r    <= req.x[DET_W-1] ? DET_W'(-req.x) : DET_W'(req.x);
        b_r    <= req.y[ENT_W-1] ? ENT_W'(-req.y) : ENT_W'(req.y);
        neg_r  <= req.x[DET_W-1] ^ req.y[ENT_W-1];
        wide_r <= req.wide;
        acc_r  <= '0;
      end else if (busy_r) begin
        // Most significant digit first
        acc_r <= (acc_r << DIG_W) + PROD_W'(pp);
        b_r   <= b_r << DIG_W;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DIGITS - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r   <= 1'b0;
        done_r  <= 1'b1;
        sat_r   <= ovf;
        value_r <= neg_r ? DET_W'(-mag_cap) : DET_W'(mag_cap);
      end
    end
  end

  assign rsp.done  = done_r;
  assign rsp.sat   = sat_r;
  assign rsp.value = value_r;

endmodule

// ----- sv/gerd_div.sv -----
// Iterative coefficient divider: -(num / den), magnitude capped at 1.0.
module gerd_div
  import gerd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CW = $clog2(FRAC_BITS + 1);
  localparam logic [FRAC_BITS:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

  logic                    busy_r, fin_r, done_r;
  logic [CW-1:0]           cnt_r;
  logic [REM_W-1:0]        rem_r, dm_r;
  logic [FRAC_BITS:0]      q_r;
  logic                    neg_r;
  logic                    sat_r;
  logic signed [ENT_W-1:0] coef_r;

  logic [REM_W-1:0]        nm, dm, rem_sh;
  logic                    take;
  logic                    q_big;
  logic [FRAC_BITS:0]      q_cap;

  always_comb begin
    nm     = REM_W'(mag_ent(req.num));
    dm     = REM_W'(mag_ent(req.den));
    rem_sh = rem_r << 1;
    take   = rem_sh >= dm_r;
    q_big  = q_r > ONE_Q;
    q_cap  = q_big ? ONE_Q : q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        neg_r <= (req.num[ENT_W-1] == req.den[ENT_W-1]);
        dm_r  <= dm;
        cnt_r <= '0;
        if (dm == '0) begin
          coef_r <= '0;
          sat_r  <= 1'b0;
          done_r <= 1'b1;
        end else if (nm >= (dm << 1)) begin
          // Quotient of two or more: cap at once
          coef_r <= (req.num[ENT_W-1] == req.den[ENT_W-1]) ? -ENT_W'(ONE_Q) : ENT_W'(ONE_Q);
          sat_r  <= 1'b1;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          q_r    <= (FRAC_BITS+1)'(nm >= dm);
          rem_r  <= (nm >= dm) ? nm - dm : nm;
        end
      end else if (busy_r) begin
        rem_r <= take ? rem_sh - dm_r : rem_sh;
        q_r   <= {q_r[FRAC_BITS-1:0], take};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(FRAC_BITS - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
        sat_r  <= q_big;
        coef_r <= neg_r ? -ENT_W'(q_cap) : ENT_W'(q_cap);
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.sat  = sat_r;
  assign rsp.coef = coef_r;

endmodule

// ----- sv/gauss_elimination_rank_det.sv -----
// Rank and determinant by Gaussian elimination with partial pivoting.
//
// Usage: write rows_in_use (0x0), cols_in_use (0x4) and epsilon (0x8) over the
// APB port while the block is idle. Stream the matrix on in_ch, row-major,
// signed Q16.16, one element per transfer, and mark the final element with
// last_element. Elements load one per cycle into a 64-entry store.
// After the final element the sequencer runs the elimination out of that
// store: a pivot search down each column, a row swap where needed, one
// coefficient division per row below the pivot and an update of every
// element of those rows (single store read port plus a 3-digit multiplier),
// then one multiply per diagonal entry for the determinant. in_ch is not
// ready meanwhile.
// out_ch carries one transfer per matrix: rank, Q32.32 determinant and the
// saturation flag. The result waits in an output register; loading of the
// next matrix may proceed while it waits, and the next result holds off
// until out_ch takes the previous one.
// Reset (rst_n, synchronous) restores the register defaults, empties the
// load position and drops any pending result; store contents are undefined.
module gauss_elimination_rank_det
  import gerd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  gerd_in_if.sink            in_ch,
  gerd_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_COL, S_SRCH_RD, S_SRCH_CMP, S_DECIDE, S_ZERO,
    S_SWP_RA, S_SWP_RB, S_SWP_WA, S_SWP_WB,
    S_ROW, S_ROW_RB, S_ROW_DIV, S_ROW_DWAIT,
    S_UPD_RA, S_UPD_RB, S_UPD_MW, S_UPD_Z,
    S_DET_INIT, S_DET_RD, S_DET_MS, S_DET_MW, S_OUT
  } state_t;

  state_t                  state_r;
  logic [CNT_W-1:0]        rows_r, cols_r;
  logic [EPS_W-1:0]        eps_cfg_r;
  logic [POS_W-1:0]        load_pos_r;
  logic [DIM_W-1:0]        m_r, n_r, lim_r;
  logic [DIM_W-1:0]        i_r, j_r, k_r, l_r, c_r;
  logic [ENT_W-1:0]        eps_r, best_r;
  logic signed [ENT_W-1:0] tmp_r, num_r, coef_r;
  logic signed [DET_W-1:0] det_r;
  logic                    sat_r;

  logic                    out_valid_r;
  logic [RANK_W-1:0]       rank_r;
  logic signed [DET_W-1:0] det_out_r;
  logic                    sat_out_r;

  logic                    mem_we, mem_re;
  logic [ADDR_W-1:0]       mem_waddr, mem_raddr;
  logic signed [ENT_W-1:0] mem_wdata, rdata;
  mul_req_t                mul_req;
  mul_rsp_t                mul_rsp;
  div_req_t                div_req;
  div_rsp_t                div_rsp;

  logic                    in_xfer, cfg_wr;
  reg_idx_t                cfg_idx;
  logic [ENT_W-1:0]        rd_mag;
  logic signed [ENT_W:0]   sum;
  logic                    sum_ovf, neg_ovf;
  logic signed [ENT_W-1:0] sum_sat, neg_sat;

  function automatic logic [ADDR_W-1:0] ent_addr(input logic [DIM_W-1:0] r,
                                                 input logic [DIM_W-1:0] c,
                                                 input logic [DIM_W-1:0] n);
    logic [2*DIM_W-1:0] p;
    p = (2*DIM_W)'(r) * (2*DIM_W)'(n) + (2*DIM_W)'(c);
    return p[ADDR_W-1:0];
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CNT_W-1:0] v);
    if (v == '0) begin
      return DIM_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      return DIM_W'(MAX_DIM);
    end
    return DIM_W'(v);
  endfunction

  gerd_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  gerd_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));
  gerd_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign pready       = 1'b1;
  assign cfg_wr       = psel && penable && pwrite;
  assign cfg_idx      = reg_idx_t'(paddr[3:2]);

  always_comb begin
    unique case (cfg_idx)
      REG_ROWS: prdata = PDATA_W'(rows_r);
      REG_COLS: prdata = PDATA_W'(cols_r);
      REG_EPS:  prdata = PDATA_W'(eps_cfg_r);
      default:  prdata = '0;
    endcase
  end

  // Row update sum and swap negation, both saturated to the entry range
  always_comb begin
    rd_mag  = mag_ent(rdata);
    sum     = (ENT_W+1)'(rdata) + (ENT_W+1)'(signed'(mul_rsp.value[ENT_W-1:0]));
    sum_ovf = sum[ENT_W] != sum[ENT_W-1];
    sum_sat = sum_ovf ? (sum[ENT_W] ? ENT_MIN : ENT_MAX) : sum[ENT_W-1:0];
    neg_ovf = (tmp_r == ENT_MIN);
    neg_sat = neg_ovf ? ENT_MAX : -tmp_r;
  end

  always_comb begin
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    mul_req       = '0;
    div_req       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && load_pos_r < POS_W'(DEPTH)) begin
          mem_we    = 1'b1;
          mem_waddr = load_pos_r[ADDR_W-1:0];
          mem_wdata = q16_to_ent(in_ch.element_value);
        end
      end
      S_SRCH_RD: begin
        mem_re    = 1'b1;
        mem_raddr = ent_addr(l_r, j_r, n_r);
      end
      S_ZERO, S_UPD_Z: begin
        mem_we    = 1'b1;
        mem_waddr = ent_addr(l_r, j_r, n_r);
      end
      S_SWP_RA, S_UPD_RA: begin
        mem_re    = 1'b1;
        mem_raddr = ent_addr(i_r, c_r, n_r);
      end
      S_SWP_RB: begin
        mem_re    = 1'b1;
        mem_raddr = ent_addr(k_r, c_r, n_r);
      end
      S_SWP_WA: begin
        mem_we    = 1'b1;
        mem_waddr = ent_addr(i_r, c_r, n_r);
        mem_wdata = rdata;
      end
      S_SWP_WB: begin
        mem_we    = 1'b1;
        mem_waddr = ent_addr(k_r, c_r, n_r);
        mem_wdata = neg_sat;
      end
      S_ROW: begin
        mem_re    = (l_r < m_r);
        mem_raddr = ent_addr(l_r, j_r, n_r);
      end
      S_ROW_RB: begin
        mem_re    = 1'b1;
        mem_raddr = ent_addr(i_r, j_r, n_r);
      end
      S_ROW_DIV: begin
        div_req.start = 1'b1;
        div_req.num   = num_r;
        div_req.den   = rdata;
      end
      S_UPD_RB: begin
        mem_re        = 1'b1;
        mem_raddr     = ent_addr(l_r, c_r, n_r);
        mul_req.start = 1'b1;
        mul_req.wide  = 1'b0;
        mul_req.x     = DET_W'(rdata);
        mul_req.y     = coef_r;
      end
      S_UPD_MW: begin
        mem_we    = mul_rsp.done;
        mem_waddr = ent_addr(l_r, c_r, n_r);
        mem_wdata = sum_sat;
      end
      S_DET_RD: begin
        mem_re    = (l_r < lim_r);
        mem_raddr = ent_addr(l_r, l_r, n_r);
      end
      S_DET_MS: begin
        mul_req.start = 1'b1;
        mul_req.wide  = 1'b1;
        mul_req.x     = det_r;
        mul_req.y     = rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rows_r      <= CNT_W'(8);
      cols_r      <= CNT_W'(8);
      eps_cfg_r   <= EPS_W'(1);
      load_pos_r  <= '0;
      i_r         <= '0;
      j_r         <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_ROWS: rows_r    <= pwdata[CNT_W-1:0];
          REG_COLS: cols_r    <= pwdata[CNT_W-1:0];
          REG_EPS:  eps_cfg_r <= pwdata[EPS_W-1:0];
          default: begin
          end
        endcase
      end
      // S_OUT sets the valid itself when it issues the next result
      if (out_valid_r && out_ch.ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            if (in_ch.last_element) begin
              load_pos_r <= '0;
              state_r    <= S_START;
            end else if (load_pos_r < POS_W'(DEPTH)) begin
              load_pos_r <= load_pos_r + 1'b1;
            end
          end
        end
        S_START: begin
          m_r     <= clamp_dim(rows_r);
          n_r     <= clamp_dim(cols_r);
          eps_r   <= q16_to_ent(ELEM_W'(eps_cfg_r));
          i_r     <= '0;
          j_r     <= '0;
          sat_r   <= 1'b0;
          state_r <= S_COL;
        end
        S_COL: begin
          l_r <= i_r;
          k_r <= i_r;
          if (i_r < m_r && j_r < n_r) begin
            state_r <= S_SRCH_RD;
          end else begin
            state_r <= S_DET_INIT;
          end
        end
        S_SRCH_RD: begin
          state_r <= S_SRCH_CMP;
        end
        S_SRCH_CMP: begin
          // First row seeds the search; later rows win only when strictly larger
          if (l_r == i_r || rd_mag > best_r) begin
            best_r <= rd_mag;
            k_r    <= l_r;
          end
          if (DIM_W'(l_r + 1'b1) < m_r) begin
            l_r     <= l_r + 1'b1;
            state_r <= S_SRCH_RD;
          end else begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          c_r <= '0;
          if (best_r <= eps_r) begin
            l_r     <= i_r;
            state_r <= S_ZERO;
          end else if (k_r != i_r) begin
            state_r <= S_SWP_RA;
          end else begin
            l_r     <= i_r + 1'b1;
            state_r <= S_ROW;
          end
        end
        S_ZERO: begin
          if (DIM_W'(l_r + 1'b1) < m_r) begin
            l_r <= l_r + 1'b1;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_COL;
          end
        end
        S_SWP_RA: begin
          state_r <= S_SWP_RB;
        end
        S_SWP_RB: begin
          tmp_r   <= rdata;
          state_r <= S_SWP_WA;
        end
        S_SWP_WA: begin
          state_r <= S_SWP_WB;
        end
        S_SWP_WB: begin
          sat_r <= sat_r | neg_ovf;
          if (DIM_W'(c_r + 1'b1) < n_r) begin
            c_r     <= c_r + 1'b1;
            state_r <= S_SWP_RA;
          end else begin
            l_r     <= i_r + 1'b1;
            state_r <= S_ROW;
          end
        end
        S_ROW: begin
          if (l_r < m_r) begin
            state_r <= S_ROW_RB;
          end else begin
            i_r     <= i_r + 1'b1;
            j_r     <= j_r + 1'b1;
            state_r <= S_COL;
          end
        end
        S_ROW_RB: begin
          num_r   <= rdata;
          state_r <= S_ROW_DIV;
        end
        S_ROW_DIV: begin
          state_r <= S_ROW_DWAIT;
        end
        S_ROW_DWAIT: begin
          if (div_rsp.done) begin
            coef_r  <= div_rsp.coef;
            sat_r   <= sat_r | div_rsp.sat;
            c_r     <= '0;
            state_r <= S_UPD_RA;
          end
        end
        S_UPD_RA: begin
          state_r <= S_UPD_RB;
        end
        S_UPD_RB: begin
          state_r <= S_UPD_MW;
        end
        S_UPD_MW: begin
          if (mul_rsp.done) begin
            sat_r <= sat_r | mul_rsp.sat | sum_ovf;
            if (DIM_W'(c_r + 1'b1) < n_r) begin
              c_r     <= c_r + 1'b1;
              state_r <= S_UPD_RA;
            end else begin
              state_r <= S_UPD_Z;
            end
          end
        end
        S_UPD_Z: begin
          l_r     <= l_r + 1'b1;
          state_r <= S_ROW;
        end
        S_DET_INIT: begin
          det_r   <= DET_ONE;
          l_r     <= '0;
          lim_r   <= (m_r < n_r) ? m_r : n_r;
          state_r <= S_DET_RD;
        end
        S_DET_RD: begin
          if (l_r < lim_r) begin
            state_r <= S_DET_MS;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_DET_MS: begin
          state_r <= S_DET_MW;
        end
        S_DET_MW: begin
          if (mul_rsp.done) begin
            det_r   <= mul_rsp.value;
            sat_r   <= sat_r | mul_rsp.sat;
            l_r     <= l_r + 1'b1;
            state_r <= S_DET_RD;
          end
        end
        S_OUT: begin
          // Hold until the previous result has been taken
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            rank_r      <= RANK_W'(i_r);
            det_out_r   <= det_r;
            sat_out_r   <= sat_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.rank          = rank_r;
  assign out_ch.determinant   = det_out_r;
  assign out_ch.det_saturated = sat_out_r;

`ifndef SYNTHESIS
  a_load_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    load_pos_r <= POS_W'(DEPTH))
    else $error("load position past store depth");

  a_pivot_not_above: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DECIDE |-> (k_r >= i_r && k_r < m_r))
    else $error("pivot row outside the active rows");

  a_result_issued: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && (!out_valid_r || out_ch.ready)) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not issued when output slot was free");

  a_pivot_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DET_INIT |-> (i_r <= m_r && j_r <= n_r && i_r <= j_r))
    else $error("pivot counters out of range after elimination");
`endif

endmodule

// ----- sim/gerd_checker.sv -----
// Scoreboard for the elimination block: tracks config, predicts rank/determinant, compares.
module gerd_checker
  import gerd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  gerd_in_if                 in_mon,
  gerd_out_if                out_mon,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 outstanding
);

  localparam logic [63:0] E_POS = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] E_NEG = 64'h0000_8000_0000_0000;
  localparam logic [63:0] D_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] D_NEG = 64'h8000_0000_0000_0000;

  typedef struct {
    logic [RANK_W-1:0] rank;
    logic [DET_W-1:0]  det;
    logic              sat;
  } det_result_t;

  det_result_t result_q[$];

  longint      cells[DEPTH];
  int          fill_pos;
  logic [3:0]  rows_cfg;
  logic [3:0]  cols_cfg;
  logic [15:0] eps_cfg;
  bit          sat_seen;

  function automatic logic [63:0] mag(input longint x);
    return x < 0 ? 64'd0 - 64'(x) : 64'(x);
  endfunction

  function automatic longint clip(input bit neg, input logic [63:0] m,
                                  input logic [63:0] pos_lim, input logic [63:0] neg_lim);
    if (neg) begin
      if (m > neg_lim) begin
        m = neg_lim;
        sat_seen = 1;
      end
      return longint'(64'd0 - m);
    end
    if (m > pos_lim) begin
      m = pos_lim;
      sat_seen = 1;
    end
    return longint'(m);
  endfunction

  function automatic longint sat_ent(input longint v);
    return clip(v < 0, mag(v), E_POS, E_NEG);
  endfunction

  // (x*y) >> FRAC_BITS, truncated toward zero
  function automatic longint fx_mul(input longint x, input longint y,
                                    input logic [63:0] pos_lim, input logic [63:0] neg_lim);
    logic [127:0] p;
    logic [63:0]  m;
    p = {64'd0, mag(x)} * {64'd0, mag(y)};
    if ((p[127:64] >> FRAC_BITS) != 0) m = '1;
    else m = p[FRAC_BITS +: 64];
    return clip((x < 0) != (y < 0), m, pos_lim, neg_lim);
  endfunction

  function automatic longint to_ent(input longint v);
    int up;
    int dn;
    up = FRAC_BITS >= 16 ? FRAC_BITS - 16 : 0;
    dn = FRAC_BITS < 16 ? 16 - FRAC_BITS : 0;
    return sat_ent((v >>> dn) <<< up);
  endfunction

  // -(num/den), capped at one
  function automatic longint neg_ratio(input longint num, input longint den);
    logic [63:0] nm, dm, q, r, one;
    nm = mag(num);
    dm = mag(den);
    one = 64'd1 << FRAC_BITS;
    if (dm == 0) return 0;
    q = nm / dm;
    r = nm % dm;
    if (q > 1) begin
      q = one;
      sat_seen = 1;
    end else begin
      for (int b = 0; b < FRAC_BITS; b++) begin
        r = r << 1;
        q = q << 1;
        if (r >= dm) begin
          r = r - dm;
          q = q | 64'd1;
        end
      end
      if (q > one) begin
        q = one;
        sat_seen = 1;
      end
    end
    return clip((num < 0) == (den < 0), q, one, one);
  endfunction

  function automatic int clamp_dim(input logic [3:0] v);
    if (v < 1) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  task automatic eliminate();
    int m, n, i, j, k;
    longint eps_q, det, t;
    logic [63:0] best;
    det_result_t res;
    m = clamp_dim(rows_cfg);
    n = clamp_dim(cols_cfg);
    eps_q = to_ent(longint'(eps_cfg));
    sat_seen = 0;
    i = 0;
    j = 0;
    while (i < m && j < n) begin
      best = mag(cells[i*n+j]);
      k = i;
      for (int l = i + 1; l < m; l++) begin
        if (mag(cells[l*n+j]) > best) begin
          best = mag(cells[l*n+j]);
          k = l;
        end
      end
      if (best <= 64'(eps_q)) begin
        for (int l = i; l < m; l++) cells[l*n+j] = 0;
        j++;
      end else begin
        if (k != i) begin
          for (int c = 0; c < n; c++) begin
            t = cells[i*n+c];
            cells[i*n+c] = cells[k*n+c];
            cells[k*n+c] = sat_ent(-t);
          end
        end
        for (int l = i + 1; l < m; l++) begin
          t = neg_ratio(cells[l*n+j], cells[i*n+j]);
          for (int c = 0; c < n; c++)
            cells[l*n+c] = sat_ent(cells[l*n+c] + fx_mul(cells[i*n+c], t, E_POS, E_NEG));
          cells[l*n+j] = 0;
        end
        i++;
        j++;
      end
    end
    det = longint'(64'd1 << 32);
    for (int l = 0; l < (m < n ? m : n); l++) det = fx_mul(det, cells[l*n+l], D_POS, D_NEG);
    res.rank = RANK_W'(i);
    res.det = 64'(det);
    res.sat = sat_seen;
    result_q.insert(result_q.size(), res);
    fill_pos = 0;
  endtask

  always @(posedge clk) begin
    det_result_t e;
    if (!rst_n) begin
      result_q.delete();
      fill_pos = 0;
      rows_cfg <= 4'd8;
      cols_cfg <= 4'd8;
      eps_cfg <= 16'd1;
      fail_count <= 0;
      outstanding <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr >> 2))
          REG_ROWS: rows_cfg <= pwdata[3:0];
          REG_COLS: cols_cfg <= pwdata[3:0];
          REG_EPS:  eps_cfg <= pwdata[15:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (fill_pos < DEPTH) begin
          cells[fill_pos] = to_ent(longint'(in_mon.element_value));
          fill_pos = fill_pos + 1;
        end
        if (in_mon.last_element) eliminate();
      end
      if (out_mon.valid && out_mon.ready) begin
        if (result_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("unexpected result: rank %0d det %h sat %0d", out_mon.rank,
                     out_mon.determinant, out_mon.det_saturated);
        end else begin
          e = result_q.pop_front();
          if (e.rank !== out_mon.rank || e.det !== out_mon.determinant ||
              e.sat !== out_mon.det_saturated) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: exp rank %0d det %h sat %0d, got rank %0d det %h sat %0d",
                       e.rank, e.det, e.sat, out_mon.rank, out_mon.determinant,
                       out_mon.det_saturated);
          end
        end
      end
      outstanding <= result_q.size();
    end
  end

endmodule

// ----- sim/tb_top.sv -----
// Stimulus and verdict for the elimination block; checking lives in gerd_checker.
module tb_top;
  import gerd_pkg::*;

  localparam int LIMIT = 1500000;

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 fail_count;
  int                 outstanding;
  int                 cycles;
  int                 sent;
  int                 idle_pct;
  int                 stall_pct;
  int                 hi_written;
  int                 m_eff;
  int                 n_eff;
  bit                 hold_go;
  bit                 rx_hold;
  logic [31:0]        vals[0:127];

  gerd_in_if  in_ch();
  gerd_out_if out_ch();

  gauss_elimination_rank_det u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  gerd_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .fail_count(fail_count), .outstanding(outstanding)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready = rx_hold ? 1'b0 : ($urandom_range(99) >= stall_pct);
  end

  // long receiver hold-off so the block fills and stalls its input
  initial begin
    rx_hold = 0;
    wait (hold_go);
    @(negedge clk);
    rx_hold = 1;
    repeat (6000) @(negedge clk);
    rx_hold = 0;
  end

  function automatic int clamp_dim(input int v);
    if (v < 1) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'd0;
      2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      3: return 32'($urandom_range(6)) - 32'd3;
      default: return 32'($urandom_range(0, 8 << 16)) - 32'(4 << 16);
    endcase
  endfunction

  // drop valid so the last element is not offered again while idle
  task automatic settle();
    in_ch.valid = 0;
    while (outstanding != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] v);
    psel = 1;
    penable = 0;
    pwrite = 1;
    paddr = PADDR_W'(idx) << 2;
    pwdata = v;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0;
    penable = 0;
    pwrite = 0;
  endtask

  task automatic configure(input int r, input int c, input int e);
    settle();
    reg_write(REG_ROWS, 32'(r));
    reg_write(REG_COLS, 32'(c));
    reg_write(REG_EPS, 32'(e));
    m_eff = clamp_dim(r);
    n_eff = clamp_dim(c);
  endtask

  task automatic put_elem(input logic [31:0] v, input bit last);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid = 0;
      @(negedge clk);
    end
    in_ch.valid = 1;
    in_ch.element_value = v;
    in_ch.last_element = last;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    sent++;
  endtask

  // count may differ from rows*cols to cover short and overfull loads
  task automatic send_matrix(input int count, input bit dup);
    for (int k = 0; k < count; k++) begin
      vals[k] = rand_elem();
      if (dup && k >= n_eff && $urandom_range(3) == 0) vals[k] = vals[k - n_eff];
    end
    for (int k = 0; k < count; k++) put_elem(vals[k], k == count - 1);
    if (count > hi_written) hi_written = count > DEPTH ? DEPTH : count;
  endtask

  initial begin
    int cnt;
    int dims[2];
    int e;
    rst_n = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 0;
    in_ch.element_value = '0;
    in_ch.last_element = 0;
    sent = 0;
    idle_pct = 0;
    stall_pct = 0;
    hi_written = 0;
    m_eff = 8;
    n_eff = 8;
    hold_go = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // full 8x8 load first so every store entry holds data
    send_matrix(64, 0);
    configure(2, 2, 0);
    put_elem(32'h7FFF_FFFF, 0);
    put_elem(32'h8000_0000, 0);
    put_elem(32'h8000_0000, 0);
    put_elem(32'h7FFF_FFFF, 1);
    configure(1, 1, 1);
    put_elem(32'h0, 1);
    put_elem(32'h8000_0000, 1);
    put_elem(32'h7FFF_FFFF, 1);
    configure(3, 3, 65535);
    put_elem(32'h1_0000, 0);
    put_elem(32'h2_0000, 0);
    put_elem(32'h3_0000, 0);
    put_elem(32'h2_0000, 0);
    put_elem(32'h4_0000, 0);
    put_elem(32'h6_0000, 0);
    put_elem(32'h0, 0);
    put_elem(32'h0, 0);
    put_elem(32'h1_0000, 1);
    configure(0, 15, 1);
    send_matrix(8, 0);
    configure(15, 0, 1);
    send_matrix(8, 0);
    configure(8, 8, 2);
    send_matrix(70, 1);
    configure(2, 3, 100);
    send_matrix(2, 0);

    while (sent < 1900) begin
      case (sent * 4 / 1900)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 56; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 6; stall_pct = 6; end
      endcase
      for (int d = 0; d < 2; d++) begin
        case ($urandom_range(19))
          0: dims[d] = 0;
          1: dims[d] = 15;
          2: dims[d] = 8;
          default: dims[d] = $urandom_range(1, 4);
        endcase
      end
      case ($urandom_range(5))
        0: e = 0;
        1: e = 65535;
        2: e = $urandom_range(0, 65535);
        3: e = $urandom_range(0, 256);
        default: e = 1;
      endcase
      configure(dims[0], dims[1], e);
      if (sent >= 900 && !hold_go) hold_go = 1;
      for (int r = 0; r < 4; r++) begin
        cnt = m_eff * n_eff;
        case ($urandom_range(9))
          0: if (cnt > 1 && cnt <= hi_written) cnt = $urandom_range(1, cnt - 1);
          1: cnt = cnt + $urandom_range(1, 3);
          default: ;
        endcase
        send_matrix(cnt, $urandom_range(2) == 0);
      end
    end
    in_ch.valid = 0;
    while (outstanding != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/gerd_pkg.sv
sv/gerd_in_if.sv
sv/gerd_out_if.sv
sv/gerd_store.sv
sv/gerd_mul.sv
sv/gerd_div.sv
sv/gauss_elimination_rank_det.sv
sim/gerd_checker.sv
sim/tb_top.sv
